FILE: rtl/wsd_pkg.sv
// shared types and constants for the websocket server deframer
`default_nettype none

package wsd_pkg;

  // width of the length limit and of the running lengths, and the reset limit
  localparam int unsigned LenW = 24;
  localparam logic [LenW-1:0] MaxLenReset = 24'd1048576;

  // largest payload of a control frame
  localparam logic [LenW-1:0] CtrlMaxLen = 24'd125;

  // seven-bit length codes that announce an extended length
  localparam logic [6:0] Len7Ext16 = 7'd126;
  localparam logic [6:0] Len7Ext64 = 7'd127;

  // extended length and mask byte counts, minus one
  localparam logic [2:0] Ext16Cnt = 3'd1;
  localparam logic [2:0] Ext64Cnt = 3'd7;
  localparam logic [2:0] MaskLastCnt = 3'd3;

  // frame opcodes
  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  // result kinds
  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_PING  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // protocol error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_FRAME_LARGE = 3'd1;
  localparam logic [2:0] ERR_BAD_CTRL    = 3'd2;
  localparam logic [2:0] ERR_UNMASKED    = 3'd3;
  localparam logic [2:0] ERR_ORPHAN_CONT = 3'd4;
  localparam logic [2:0] ERR_DATA_MID    = 3'd5;
  localparam logic [2:0] ERR_BAD_OPCODE  = 3'd6;
  localparam logic [2:0] ERR_MSG_LARGE   = 3'd7;

  // parser phase, one-hot
  typedef enum logic [4:0] {
    PH_HEAD0   = 5'b00001,
    PH_HEAD1   = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_MASK    = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_e;

  // one result from the parser core
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic       has_byte;
    logic [7:0] data;
    logic       last;
    logic [2:0] err;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/wsd_core.sv
// frame parser state and per-byte decode of the websocket deframer
`default_nettype none

module wsd_core
  import wsd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic [LenW-1:0] limit_i,
  output result_t              result_o
);

  phase_e          phase_q, phase_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            final_q, final_d;
  logic [3:0]      op_q, op_d;
  logic [LenW-1:0] len_q, len_d;
  logic            over_q, over_d;
  logic [31:0]     key_q, key_d;
  logic [1:0]      idx_q, idx_d;
  logic            in_msg_q, in_msg_d;
  logic            is_text_q, is_text_d;
  logic [LenW-1:0] msg_len_q, msg_len_d;
  logic            halted_q, halted_d;
  logic            masked_q, masked_d;

  // header completion inputs
  logic            hd_take;
  logic [LenW-1:0] hd_len;
  logic            hd_over;
  logic            hd_masked;
  logic            is_ctrl;
  logic [LenW:0]   msg_sum;
  logic [2:0]      hd_err;

  // payload datapath
  logic [7:0]      key_byte;
  logic [7:0]      plain;
  logic [LenW-1:0] len_dec;
  logic            fe_take;
  logic            fe_has;

  // header length and mask bit as seen at the byte that completes the header
  always_comb begin
    hd_take   = 1'b0;
    hd_len    = '0;
    hd_over   = 1'b0;
    hd_masked = masked_q;
    case (phase_q)
      PH_HEAD1: begin
        hd_take   = (byte_i[6:0] != Len7Ext16) && (byte_i[6:0] != Len7Ext64);
        hd_len    = {{(LenW-7){1'b0}}, byte_i[6:0]};
        hd_masked = byte_i[7];
      end
      PH_EXTLEN: begin
        hd_take = (cnt_q == '0);
        hd_len  = {len_q[LenW-9:0], byte_i};
        hd_over = over_q | (len_q[LenW-1:LenW-8] != '0);
      end
      default: begin
        hd_take = 1'b0;
      end
    endcase
  end

  // header error check, first failing rule wins
  always_comb begin
    is_ctrl = (op_q == OP_CLOSE) || (op_q == OP_PING) || (op_q == OP_PONG);
    msg_sum = {1'b0, msg_len_q} + {1'b0, hd_len};
    hd_err  = ERR_NONE;
    if (hd_over || (hd_len > limit_i)) begin
      hd_err = ERR_FRAME_LARGE;
    end else if (is_ctrl && ((hd_len > CtrlMaxLen) || !final_q)) begin
      hd_err = ERR_BAD_CTRL;
    end else if (!hd_masked) begin
      hd_err = ERR_UNMASKED;
    end else if (op_q == OP_CONT) begin
      if (!in_msg_q) begin
        hd_err = ERR_ORPHAN_CONT;
      end else if (is_text_q && (msg_sum > {1'b0, limit_i})) begin
        hd_err = ERR_MSG_LARGE;
      end
    end else if ((op_q == OP_TEXT) || (op_q == OP_BIN)) begin
      if (in_msg_q) begin
        hd_err = ERR_DATA_MID;
      end
    end else if (!is_ctrl) begin
      hd_err = ERR_BAD_OPCODE;
    end
  end

  // unmasking with the rotating key byte
  always_comb begin
    case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
    plain   = byte_i ^ key_byte;
    len_dec = (len_q != '0) ? (len_q - 1'b1) : len_q;
  end

  // next state and result for the byte on hand
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    final_d   = final_q;
    op_d      = op_q;
    len_d     = len_q;
    over_d    = over_q;
    key_d     = key_q;
    idx_d     = idx_q;
    in_msg_d  = in_msg_q;
    is_text_d = is_text_q;
    msg_len_d = msg_len_q;
    halted_d  = halted_q;
    masked_d  = masked_q;
    fe_take   = 1'b0;
    fe_has    = 1'b0;
    result_o  = '0;

    if (step_i && !halted_q) begin
      case (phase_q)
        PH_HEAD0: begin
          final_d = byte_i[7];
          op_d    = byte_i[3:0];
          phase_d = PH_HEAD1;
        end
        PH_HEAD1: begin
          masked_d = byte_i[7];
          len_d    = '0;
          over_d   = 1'b0;
          phase_d  = PH_EXTLEN;
          if (byte_i[6:0] == Len7Ext16) begin
            cnt_d = Ext16Cnt;
          end else begin
            cnt_d = Ext64Cnt;
          end
        end
        PH_EXTLEN: begin
          len_d  = hd_len;
          over_d = hd_over;
          cnt_d  = cnt_q - 1'b1;
        end
        PH_MASK: begin
          key_d = {key_q[23:0], byte_i};
          if (cnt_q != MaskLastCnt) begin
            cnt_d = cnt_q + 1'b1;
          end else begin
            cnt_d = '0;
            idx_d = '0;
            if (len_q == '0) begin
              fe_take = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          idx_d = idx_q + 1'b1;
          len_d = len_dec;
          if (len_dec == '0) begin
            fe_take = 1'b1;
            fe_has  = 1'b1;
          end else if ((op_q <= OP_BIN) && is_text_q) begin
            result_o = '{valid: 1'b1, kind: KIND_TEXT, has_byte: 1'b1, data: plain,
                         last: 1'b0, err: ERR_NONE};
          end else if (op_q == OP_PING) begin
            result_o = '{valid: 1'b1, kind: KIND_PING, has_byte: 1'b1, data: plain,
                         last: 1'b0, err: ERR_NONE};
          end
        end
        default: begin
          phase_d = PH_HEAD0;
        end
      endcase

      // header complete: report an error or set up the message and mask
      if (hd_take) begin
        if (hd_err != ERR_NONE) begin
          halted_d = 1'b1;
          result_o = '{valid: 1'b1, kind: KIND_ERROR, has_byte: 1'b0, data: 8'd0,
                       last: 1'b0, err: hd_err};
        end else begin
          if (op_q <= OP_BIN) begin
            if (op_q == OP_CONT) begin
              if (is_text_q) begin
                msg_len_d = msg_sum[LenW-1:0];
              end
            end else begin
              is_text_d = (op_q == OP_TEXT);
              msg_len_d = (op_q == OP_TEXT) ? hd_len : '0;
            end
            in_msg_d = !final_q;
          end
          len_d   = hd_len;
          over_d  = hd_over;
          phase_d = PH_MASK;
          cnt_d   = '0;
          key_d   = '0;
          idx_d   = '0;
        end
      end

      // end of frame payload
      if (fe_take) begin
        phase_d = PH_HEAD0;
        if (op_q <= OP_BIN) begin
          if (is_text_q && (fe_has || final_q)) begin
            result_o = '{valid: 1'b1, kind: KIND_TEXT, has_byte: fe_has,
                         data: fe_has ? plain : 8'd0, last: final_q, err: ERR_NONE};
          end
        end else if (op_q == OP_PING) begin
          result_o = '{valid: 1'b1, kind: KIND_PING, has_byte: fe_has,
                       data: fe_has ? plain : 8'd0, last: 1'b1, err: ERR_NONE};
        end else if (op_q == OP_CLOSE) begin
          halted_d = 1'b1;
          result_o = '{valid: 1'b1, kind: KIND_CLOSE, has_byte: 1'b0, data: 8'd0,
                       last: 1'b0, err: ERR_NONE};
        end
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEAD0;
      cnt_q     <= '0;
      final_q   <= 1'b0;
      op_q      <= '0;
      len_q     <= '0;
      over_q    <= 1'b0;
      key_q     <= '0;
      idx_q     <= '0;
      in_msg_q  <= 1'b0;
      is_text_q <= 1'b0;
      msg_len_q <= '0;
      halted_q  <= 1'b0;
      masked_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      final_q   <= final_d;
      op_q      <= op_d;
      len_q     <= len_d;
      over_q    <= over_d;
      key_q     <= key_d;
      idx_q     <= idx_d;
      in_msg_q  <= in_msg_d;
      is_text_q <= is_text_d;
      msg_len_q <= msg_len_d;
      halted_q  <= halted_d;
      masked_q  <= masked_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/websocket_server_deframer.sv
// top level of the websocket server deframer
// Usage: client-to-server websocket stream bytes enter on the in channel
// (in_valid_i / in_ready_o / data_byte_i), one request per byte. Results leave
// on the out channel: text bytes, ping bytes for a pong reply, a close
// indication, or a protocol error code; a byte may yield no result.
// The max_message_len limit is written on the cfg channel, which is always
// ready; write it only while no bytes are in flight.
// Path: an accepted byte sits in the input register, and its decode is captured
// in the output register, which presents the result.
// Throughput: one byte per cycle while the out channel is not held, set by the
// single decode stage between the input register and the output register.
// Stall: while the out channel is held, the decode stage stops and the input
// register holds one byte; in_ready_o drops once both are full.
// Reset: parser waits for the first header byte, limit returns to 1048576.
// After a protocol error or a close, all further bytes are taken and dropped
// until reset.
`default_nettype none

module websocket_server_deframer
  import wsd_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [LenW-1:0] cfg_max_message_len_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      data_byte_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [1:0]           kind_o,
  output logic                 has_byte_o,
  output logic [7:0]           payload_byte_o,
  output logic                 last_o,
  output logic [2:0]           error_code_o
);

  logic [LenW-1:0] limit_q;
  logic            in_valid_q, in_valid_d;
  logic [7:0]      in_byte_q;
  logic            out_valid_q, out_valid_d;
  result_t         out_q;
  logic            advance;
  result_t         result;

  // limit register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= MaxLenReset;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_max_message_len_i;
    end
  end

  // decode advances when the output register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register valid
  always_comb begin
    in_valid_d = in_valid_q;
    if (advance) begin
      in_valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= data_byte_i;
    end
  end

  // frame parser
  wsd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .limit_i  (limit_q),
    .result_o (result)
  );

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (advance && result.valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.valid) begin
      out_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_q.kind;
  assign has_byte_o     = out_q.has_byte;
  assign payload_byte_o = out_q.data;
  assign last_o         = out_q.last;
  assign error_code_o   = out_q.err;

endmodule

`default_nettype wire
